// ===== rtl/core/multi_queue_task_deque_macros.svh =====
// assertion macros for the task deque checker
// expects clk and rst_n in the scope of use
`ifndef MULTI_QUEUE_TASK_DEQUE_MACROS_SVH
`define MULTI_QUEUE_TASK_DEQUE_MACROS_SVH

// same-cycle implication
`define MQTD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task deque check failed");

// next-cycle implication
`define MQTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task deque check failed");

`endif

// ===== rtl/core/mqtd_pkg.sv =====
// shared types and codes for the multi queue task deque
// no dependencies
package mqtd_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int REC_W    = 256;
    localparam int IN_DW    = 232;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_NONE       = 2'd3
    } op_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED_BACK    = 3'd0,
        ST_PUSHED_FRONT   = 3'd1,
        ST_POPPED_SHIFTED = 3'd2,
        ST_POPPED_SINGLE  = 3'd3,
        ST_FULL           = 3'd4,
        ST_EMPTY          = 3'd5,
        ST_IGNORED        = 3'd6
    } status_e;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CALC,
        BK_FETCH
    } bk_state_e;

    // first member sits in the top bits
    typedef struct packed {
        logic [31:0] started_at;
        logic [31:0] queued_at;
        logic [15:0] sub_kind;
        logic [31:0] arg_d;
        logic [31:0] arg_c;
        logic [31:0] arg_b;
        logic [31:0] arg_a;
        logic [31:0] pending;
        logic [15:0] kind;
    } task_rec_t;

    typedef struct packed {
        op_e       op;
        task_rec_t rec;
    } cmd_t;

endpackage

// ===== rtl/core/multi_queue_task_deque.sv =====
// Bank of bounded task deques, one per player and group, each holding up to QUEUE_DEPTH
// records. A request pushes back, pushes front or pops front on one queue and returns one
// result with a status, the new count and the record in slot 0. Requests go through a
// two-entry command buffer; the back end takes one request at a time in two steps (metadata
// read, then record read plus metadata write) and accepts the next request only as the last
// result is loaded, so it stalls while that result is not taken. The steps are split by the
// single read port of the per-queue metadata memory and of the record memory. After reset
// the records, 2**(clog2(queues)+clog2(QUEUE_DEPTH)) entries or 2048 with the default sizes,
// and the metadata are swept to zero, and s_axis_tready stays low for that time.
// top level of the task deque; depends on mqtd_pkg, mqtd_front and mqtd_back
module multi_queue_task_deque
    import mqtd_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 64,
    parameter int PLAYER_COUNT = 4,
    parameter int GROUP_COUNT  = 8,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_DW      = ((CNT_W + REC_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // player, group, task_kind, pending_value, arg_a, arg_b, arg_c, arg_d, sub_kind, now_time
    input  logic [IN_DW-1:0]    s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // new_count, head_kind, head_pending, head_arg_a, head_arg_b, head_arg_c, head_arg_d,
    // head_sub_kind, head_queued_at, head_started_at
    output logic [OUT_DW-1:0]   m_axis_tdata,
    // status
    output logic [STATUS_W-1:0] m_axis_tuser
);

    localparam int QUEUE_TOTAL = PLAYER_COUNT * GROUP_COUNT;
    localparam int QI_W        = (QUEUE_TOTAL > 1) ? $clog2(QUEUE_TOTAL) : 1;

    logic            clearing;
    logic            cmd_valid;
    logic            cmd_ready;
    cmd_t            cmd;
    logic [QI_W-1:0] cmd_qidx;

    mqtd_front #(
        .PLAYER_COUNT (PLAYER_COUNT),
        .GROUP_COUNT  (GROUP_COUNT),
        .QI_W         (QI_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clearing      (clearing),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .cmd_qidx      (cmd_qidx)
    );

    mqtd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .QI_W        (QI_W),
        .OUT_DW      (OUT_DW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clearing      (clearing),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .cmd_qidx      (cmd_qidx),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/mqtd_front.sv =====
// front end: accepts requests, reduces the queue selector, buffers commands
// depends on mqtd_pkg
module mqtd_front
    import mqtd_pkg::*;
#(
    parameter int PLAYER_COUNT = 4,
    parameter int GROUP_COUNT  = 8,
    parameter int QI_W         = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_DW-1:0] s_axis_tdata,
    input  logic [FUNC_W-1:0] s_axis_tuser,
    input  logic             clearing,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output cmd_t             cmd,
    output logic [QI_W-1:0]  cmd_qidx
);

    logic [4:0]      p_red;
    logic [6:0]      g_red;
    logic [QI_W-1:0] qidx_in;
    cmd_t            cmd_in;

    cmd_t            fifo_cmd_reg [2];
    logic [QI_W-1:0] fifo_q_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            push;
    logic            pop;

    always_comb
    begin
        p_red = 5'(s_axis_tdata[1:0]);
        for (int i = 0; i < 3; i++)
        begin
            if (p_red >= 5'(PLAYER_COUNT))
            begin
                p_red = p_red - 5'(PLAYER_COUNT);
            end
        end
        g_red = 7'(s_axis_tdata[4:2]);
        for (int j = 0; j < 7; j++)
        begin
            if (g_red >= 7'(GROUP_COUNT))
            begin
                g_red = g_red - 7'(GROUP_COUNT);
            end
        end
        qidx_in = QI_W'(p_red) * QI_W'(GROUP_COUNT) + QI_W'(g_red);
    end

    always_comb
    begin
        cmd_in.op             = op_e'(s_axis_tuser);
        cmd_in.rec.kind       = s_axis_tdata[20:5];
        cmd_in.rec.pending    = s_axis_tdata[52:21];
        cmd_in.rec.arg_a      = s_axis_tdata[84:53];
        cmd_in.rec.arg_b      = s_axis_tdata[116:85];
        cmd_in.rec.arg_c      = s_axis_tdata[148:117];
        cmd_in.rec.arg_d      = s_axis_tdata[180:149];
        cmd_in.rec.sub_kind   = s_axis_tdata[196:181];
        cmd_in.rec.queued_at  = s_axis_tdata[228:197];
        cmd_in.rec.started_at = s_axis_tdata[228:197];
    end

    assign s_axis_tready = (fill_reg != 2'd2) && !clearing;
    assign cmd_valid     = (fill_reg != 2'd0);
    assign cmd           = fifo_cmd_reg[rd_ptr_reg];
    assign cmd_qidx      = fifo_q_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_cmd_reg[wr_ptr_reg] <= cmd_in;
            fifo_q_reg[wr_ptr_reg]   <= qidx_in;
        end
    end

endmodule

// ===== rtl/core/mqtd_back.sv =====
// back end: per-queue metadata and record memories, sequencer, result register
// depends on mqtd_pkg
module mqtd_back
    import mqtd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int QI_W        = 5,
    parameter int OUT_DW      = 272
)
(
    input  logic                clk,
    input  logic                rst_n,
    output logic                clearing,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  cmd_t                cmd,
    input  logic [QI_W-1:0]     cmd_qidx,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_DW-1:0]   m_axis_tdata,
    output logic [STATUS_W-1:0] m_axis_tuser
);

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W    = QI_W + SLOT_W;
    localparam int REC_DEPTH = 1 << ADDR_W;
    localparam int META_W    = CNT_W + SLOT_W;
    localparam int META_DEP  = 1 << QI_W;
    localparam int SUM_W     = CNT_W + 1;

    bk_state_e state_reg;
    bk_state_e state_next;

    logic [ADDR_W-1:0] clr_idx_reg;
    logic [ADDR_W-1:0] clr_idx_next;

    cmd_t              cmd_reg;
    logic [QI_W-1:0]   qidx_reg;

    logic [META_W-1:0] meta_mem [META_DEP];
    logic [META_W-1:0] meta_rd_reg;
    logic              meta_we;
    logic [QI_W-1:0]   meta_waddr;
    logic [META_W-1:0] meta_wdata;

    task_rec_t         rec_mem [REC_DEPTH];
    task_rec_t         rec_rd_reg;
    logic              rec_we;
    logic [ADDR_W-1:0] rec_waddr;
    task_rec_t         rec_wdata;
    logic              rec_re;
    logic [ADDR_W-1:0] rec_raddr;

    status_e           status_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              use_cmd_reg;
    logic              pf_reg;
    logic [SLOT_W-1:0] pf_slot_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_e           out_status_reg;
    logic [CNT_W-1:0]  out_count_reg;
    task_rec_t         out_rec_reg;

    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] head;
    logic              is_full;
    logic [SUM_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] next_slot;
    logic [SLOT_W-1:0] prev_slot;

    status_e           calc_status;
    logic [CNT_W-1:0]  calc_count;
    logic [SLOT_W-1:0] calc_head;
    logic [SLOT_W-1:0] rd_slot;
    logic              calc_use_cmd;
    logic              calc_pf;
    logic              pb_write;

    logic              advance;
    logic              issue;
    logic              out_load;
    task_rec_t         pf_rec;
    task_rec_t         res_rec;

    assign cnt       = meta_rd_reg[META_W-1:SLOT_W];
    assign head      = meta_rd_reg[SLOT_W-1:0];
    assign is_full   = (cnt == CNT_W'(QUEUE_DEPTH));
    assign tail_sum  = SUM_W'(head) + SUM_W'(cnt);
    assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
    assign next_slot = (head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    assign prev_slot = (head == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : head - 1'b1;

    // operation decode on the fetched queue metadata
    always_comb
    begin
        calc_status  = ST_IGNORED;
        calc_count   = cnt;
        calc_head    = head;
        rd_slot      = head;
        calc_use_cmd = 1'b0;
        calc_pf      = 1'b0;
        pb_write     = 1'b0;
        case (cmd_reg.op)
            OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    calc_status = ST_FULL;
                end
                else
                begin
                    calc_status  = ST_PUSHED_BACK;
                    calc_count   = cnt + 1'b1;
                    pb_write     = 1'b1;
                    calc_use_cmd = (cnt == '0);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    calc_status = ST_FULL;
                end
                else
                begin
                    calc_status  = ST_PUSHED_FRONT;
                    calc_count   = cnt + 1'b1;
                    calc_head    = prev_slot;
                    calc_use_cmd = 1'b1;
                    calc_pf      = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (cnt == '0)
                begin
                    calc_status = ST_EMPTY;
                end
                else if (cnt == CNT_W'(1))
                begin
                    calc_status = ST_POPPED_SINGLE;
                    calc_count  = '0;
                end
                else
                begin
                    calc_status = ST_POPPED_SHIFTED;
                    calc_count  = cnt - 1'b1;
                    calc_head   = next_slot;
                    rd_slot     = next_slot;
                end
            end
            default:
            begin
                calc_status = ST_IGNORED;
            end
        endcase
    end

    assign advance = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_idx_reg == '1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_CALC;
                end
            end
            BK_CALC:
            begin
                state_next = BK_FETCH;
            end
            BK_FETCH:
            begin
                if (advance)
                begin
                    state_next = cmd_valid ? BK_CALC : BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clearing     = (state_reg == BK_CLEAR);
        cmd_ready    = (state_reg == BK_IDLE) || ((state_reg == BK_FETCH) && advance);
        issue        = cmd_valid && cmd_ready;
        out_load     = (state_reg == BK_FETCH) && advance;
        clr_idx_next = clearing ? clr_idx_reg + 1'b1 : clr_idx_reg;

        pf_rec            = cmd_reg.rec;
        pf_rec.queued_at  = rec_rd_reg.queued_at;
        pf_rec.started_at = rec_rd_reg.started_at;
        if (use_cmd_reg)
        begin
            res_rec = pf_reg ? pf_rec : cmd_reg.rec;
        end
        else
        begin
            res_rec = rec_rd_reg;
        end

        meta_we    = clearing || (state_reg == BK_CALC);
        meta_waddr = clearing ? clr_idx_reg[ADDR_W-1 -: QI_W] : qidx_reg;
        meta_wdata = clearing ? '0 : {calc_count, calc_head};

        rec_we    = 1'b0;
        rec_waddr = clr_idx_reg;
        rec_wdata = '0;
        if (clearing)
        begin
            rec_we = 1'b1;
        end
        else if ((state_reg == BK_CALC) && pb_write)
        begin
            rec_we    = 1'b1;
            rec_waddr = {qidx_reg, tail_slot};
            rec_wdata = cmd_reg.rec;
        end
        else if (out_load && pf_reg)
        begin
            rec_we    = 1'b1;
            rec_waddr = {qidx_reg, pf_slot_reg};
            rec_wdata = pf_rec;
        end

        rec_re    = (state_reg == BK_CALC);
        rec_raddr = {qidx_reg, rd_slot};

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmd_reg     <= cmd;
            qidx_reg    <= cmd_qidx;
            meta_rd_reg <= meta_mem[cmd_qidx];
        end
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re)
        begin
            rec_rd_reg <= rec_mem[rec_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_CALC)
        begin
            status_reg  <= calc_status;
            count_reg   <= calc_count;
            use_cmd_reg <= calc_use_cmd;
            pf_reg      <= calc_pf;
            pf_slot_reg <= prev_slot;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
            out_rec_reg    <= res_rec;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'({out_rec_reg, out_count_reg});
    assign m_axis_tuser  = out_status_reg;

endmodule

// ===== rtl/core/mqtd_chk.sv =====
// port-level checker for the task deque, bound to the top level
// depends on mqtd_pkg and multi_queue_task_deque_macros.svh
`include "multi_queue_task_deque_macros.svh"

module mqtd_chk
    import mqtd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_DW     = ((CNT_W + REC_W + 7) / 8) * 8
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OUT_DW-1:0]   m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    logic [CNT_W-1:0] res_count;
    logic             drained_st;
    logic             pushed_st;

    assign res_count  = m_axis_tdata[CNT_W-1:0];
    assign drained_st = (m_axis_tuser == ST_EMPTY) || (m_axis_tuser == ST_POPPED_SINGLE);
    assign pushed_st  = (m_axis_tuser == ST_PUSHED_BACK) || (m_axis_tuser == ST_PUSHED_FRONT);

    `MQTD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `MQTD_ASSERT_IMPLY(a_count_bound, m_axis_tvalid, res_count <= CNT_W'(QUEUE_DEPTH))
    `MQTD_ASSERT_IMPLY(a_drained_zero, m_axis_tvalid && drained_st, res_count == '0)
    `MQTD_ASSERT_IMPLY(a_pushed_nonzero, m_axis_tvalid && pushed_st, res_count != '0)

endmodule

bind multi_queue_task_deque mqtd_chk #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mqtd_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb.sv =====
// self-checking testbench for multi_queue_task_deque: directed table, then random bursts
// keeps its own model of every deque and checks each result transaction field by field
// depends on mqtd_pkg and the multi_queue_task_deque rtl
module tb;
    import mqtd_pkg::*;

    localparam int QDEPTH     = 64;
    localparam int PLAYERS    = 4;
    localparam int GROUPS     = 8;
    localparam int QUEUES     = PLAYERS * GROUPS;
    localparam int OUT_W      = 264;
    localparam int RAND_ITEMS = 1600;
    localparam int BURST_LEN  = 150;
    localparam int DIR_ROWS   = 21;

    typedef enum int {
        FILL_MODE,
        DRAIN_MODE,
        MIXED_MODE
    } burst_mode_e;

    typedef struct packed {
        op_e         op;
        logic [1:0]  player;
        logic [2:0]  group;
        task_rec_t   rec;
        logic [31:0] now;
    } deque_req_t;

    typedef struct packed {
        status_e     st;
        logic [6:0]  cnt;
        task_rec_t   head;
    } deque_result_t;

    typedef struct {
        op_e         op;
        logic [1:0]  player;
        logic [2:0]  group;
        logic [31:0] word;
        logic [31:0] now;
        logic        typed;
        status_e     st;
        logic [6:0]  cnt;
        logic [31:0] hword;
        logic [31:0] htime;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata = '0;
    logic [FUNC_W-1:0]   s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    logic [6:0]    fill_count [QUEUES];
    logic [5:0]    head_slot [QUEUES];
    task_rec_t     slot_store [QUEUES][QDEPTH];
    deque_result_t expected_heads [$];
    int            mismatch_count = 0;
    int            src_idle = 0;
    int            sink_idle = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{OP_POP_FRONT,  2'd0, 3'd0, 32'h0,        32'h0,        1'b1, ST_EMPTY,
          7'd0, 32'h0,        32'h0},
        '{OP_NONE,       2'd3, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_IGNORED,
          7'd0, 32'h0,        32'h0},
        '{OP_PUSH_FRONT, 2'd1, 3'd2, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_PUSHED_FRONT,
          7'd1, 32'hFFFFFFFF, 32'h0},
        '{OP_PUSH_BACK,  2'd3, 3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, ST_PUSHED_BACK,
          7'd1, 32'hFFFFFFFF, 32'hFFFFFFFF},
        '{OP_POP_FRONT,  2'd3, 3'd7, 32'h0,        32'h0,        1'b1, ST_POPPED_SINGLE,
          7'd0, 32'hFFFFFFFF, 32'hFFFFFFFF},
        '{OP_PUSH_FRONT, 2'd3, 3'd7, 32'h0,        32'h5,        1'b1, ST_PUSHED_FRONT,
          7'd1, 32'h0,        32'hFFFFFFFF},
        '{OP_PUSH_BACK,  2'd3, 3'd7, 32'h12345678, 32'h100,      1'b0, ST_PUSHED_BACK,
          7'd0, 32'h0,        32'h0},
        '{OP_POP_FRONT,  2'd3, 3'd7, 32'h0,        32'h0,        1'b0, ST_POPPED_SHIFTED,
          7'd0, 32'h0,        32'h0},
        '{OP_NONE,       2'd3, 3'd7, 32'h0,        32'h0,        1'b0, ST_IGNORED,
          7'd0, 32'h0,        32'h0},
        '{OP_POP_FRONT,  2'd1, 3'd2, 32'h0,        32'h0,        1'b1, ST_POPPED_SINGLE,
          7'd0, 32'hFFFFFFFF, 32'h0},
        '{OP_POP_FRONT,  2'd1, 3'd2, 32'h0,        32'h0,        1'b1, ST_EMPTY,
          7'd0, 32'hFFFFFFFF, 32'h0},
        '{OP_PUSH_BACK,  2'd0, 3'd0, 32'hA5A5A5A5, 32'h0,        1'b0, ST_PUSHED_BACK,
          7'd0, 32'h0,        32'h0},
        '{OP_PUSH_BACK,  2'd0, 3'd0, 32'h5A5A5A5A, 32'hFFFFFFFF, 1'b0, ST_PUSHED_BACK,
          7'd0, 32'h0,        32'h0},
        '{OP_PUSH_FRONT, 2'd0, 3'd0, 32'h0F0F0F0F, 32'h0,        1'b0, ST_PUSHED_FRONT,
          7'd0, 32'h0,        32'h0},
        '{OP_POP_FRONT,  2'd0, 3'd0, 32'h0,        32'h0,        1'b0, ST_POPPED_SHIFTED,
          7'd0, 32'h0,        32'h0},
        '{OP_POP_FRONT,  2'd0, 3'd0, 32'h0,        32'h0,        1'b0, ST_POPPED_SHIFTED,
          7'd0, 32'h0,        32'h0},
        '{OP_POP_FRONT,  2'd0, 3'd0, 32'h0,        32'h0,        1'b0, ST_POPPED_SINGLE,
          7'd0, 32'h0,        32'h0},
        '{OP_POP_FRONT,  2'd0, 3'd0, 32'h0,        32'h0,        1'b0, ST_EMPTY,
          7'd0, 32'h0,        32'h0},
        '{OP_PUSH_BACK,  2'd2, 3'd5, 32'h0,        32'h0,        1'b1, ST_PUSHED_BACK,
          7'd1, 32'h0,        32'h0},
        '{OP_PUSH_FRONT, 2'd2, 3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, ST_PUSHED_FRONT,
          7'd0, 32'h0,        32'h0},
        '{OP_NONE,       2'd0, 3'd3, 32'h0,        32'h0,        1'b1, ST_IGNORED,
          7'd0, 32'h0,        32'h0}
    };

    multi_queue_task_deque #(
        .QUEUE_DEPTH  (QDEPTH),
        .PLAYER_COUNT (PLAYERS),
        .GROUP_COUNT  (GROUPS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic task_rec_t spread(input logic [31:0] word, input logic [31:0] stamp);
        task_rec_t rec;
        rec.kind       = word[15:0];
        rec.pending    = word;
        rec.arg_a      = word;
        rec.arg_b      = word;
        rec.arg_c      = word;
        rec.arg_d      = word;
        rec.sub_kind   = word[15:0];
        rec.queued_at  = stamp;
        rec.started_at = stamp;
        return rec;
    endfunction

    function automatic deque_result_t apply_request(input deque_req_t r);
        int            qi;
        logic [6:0]    cnt;
        logic [5:0]    hd;
        logic [5:0]    slot;
        task_rec_t     rec;
        deque_result_t res;
        qi  = r.player * GROUPS + r.group;
        cnt = fill_count[qi];
        hd  = head_slot[qi];
        rec = r.rec;
        case (r.op)
            OP_PUSH_BACK:
            begin
                if (cnt >= QDEPTH)
                    res.st = ST_FULL;
                else
                begin
                    slot = hd + cnt[5:0];
                    rec.queued_at  = r.now;
                    rec.started_at = r.now;
                    slot_store[qi][slot] = rec;
                    fill_count[qi] = cnt + 7'd1;
                    res.st = ST_PUSHED_BACK;
                end
            end
            OP_PUSH_FRONT:
            begin
                if (cnt >= QDEPTH)
                    res.st = ST_FULL;
                else
                begin
                    slot = hd - 6'd1;
                    // new head inherits the time stamps of the old slot 0, stale or not
                    rec.queued_at  = slot_store[qi][hd].queued_at;
                    rec.started_at = slot_store[qi][hd].started_at;
                    slot_store[qi][slot] = rec;
                    head_slot[qi] = slot;
                    fill_count[qi] = cnt + 7'd1;
                    res.st = ST_PUSHED_FRONT;
                end
            end
            OP_POP_FRONT:
            begin
                if (cnt == 7'd0)
                    res.st = ST_EMPTY;
                else if (cnt == 7'd1)
                begin
                    fill_count[qi] = 7'd0;
                    res.st = ST_POPPED_SINGLE;
                end
                else
                begin
                    head_slot[qi] = hd + 6'd1;
                    fill_count[qi] = cnt - 7'd1;
                    res.st = ST_POPPED_SHIFTED;
                end
            end
            default:
                res.st = ST_IGNORED;
        endcase
        res.cnt  = fill_count[qi];
        res.head = slot_store[qi][head_slot[qi]];
        return res;
    endfunction

    // starts and ends at a falling edge
    task automatic send_request(input deque_req_t r, input logic typed,
                                input deque_result_t typed_res);
        deque_result_t pred;
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {3'b000, r.now, r.rec.sub_kind, r.rec.arg_d, r.rec.arg_c,
                          r.rec.arg_b, r.rec.arg_a, r.rec.pending, r.rec.kind,
                          r.group, r.player};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = apply_request(r);
        expected_heads.push_back(typed ? typed_res : pred);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_heads.size() != 0);
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);

    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        task_rec_t     got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_heads.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual status %0h count %0d",
                         $time, m_axis_tuser, m_axis_tdata[6:0]);
            end
            else
            begin
                want = expected_heads.pop_front();
                got  = task_rec_t'(m_axis_tdata[262:7]);
                check_field("status", 32'(want.st), 32'(m_axis_tuser));
                check_field("new_count", 32'(want.cnt), 32'(m_axis_tdata[6:0]));
                check_field("head_kind", 32'(want.head.kind), 32'(got.kind));
                check_field("head_pending", want.head.pending, got.pending);
                check_field("head_arg_a", want.head.arg_a, got.arg_a);
                check_field("head_arg_b", want.head.arg_b, got.arg_b);
                check_field("head_arg_c", want.head.arg_c, got.arg_c);
                check_field("head_arg_d", want.head.arg_d, got.arg_d);
                check_field("head_sub_kind", 32'(want.head.sub_kind), 32'(got.sub_kind));
                check_field("head_queued_at", want.head.queued_at, got.queued_at);
                check_field("head_started_at", want.head.started_at, got.started_at);
            end
        end
    end

    initial
    begin : stimulus
        deque_req_t    req;
        deque_result_t typed_res;
        burst_mode_e   mode;
        int            hot_q;
        int            qi;
        int            pick;
        mode  = MIXED_MODE;
        hot_q = 0;
        for (int q = 0; q < QUEUES; q++)
        begin
            fill_count[q] = '0;
            head_slot[q]  = '0;
            for (int s = 0; s < QDEPTH; s++)
                slot_store[q][s] = '0;
        end
        src_idle  = 11;
        sink_idle = 45;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            req.op     = dir_tab[i].op;
            req.player = dir_tab[i].player;
            req.group  = dir_tab[i].group;
            req.rec    = spread(dir_tab[i].word, 32'h0);
            req.now    = dir_tab[i].now;
            typed_res.st   = dir_tab[i].st;
            typed_res.cnt  = dir_tab[i].cnt;
            typed_res.head = spread(dir_tab[i].hword, dir_tab[i].htime);
            send_request(req, dir_tab[i].typed, typed_res);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 3)
            begin
                drain_results();
                src_idle  = 45;
                sink_idle = 11;
            end
            else if (n == 2 * RAND_ITEMS / 3)
            begin
                drain_results();
                src_idle  = 0;
                sink_idle = 0;
            end
            if (n % BURST_LEN == 0)
            begin
                mode  = burst_mode_e'($urandom_range(0, 2));
                hot_q = $urandom_range(0, QUEUES - 1);
            end
            // most traffic hits one queue per burst so that it fills up or runs dry
            qi   = ($urandom_range(0, 99) < 80) ? hot_q : $urandom_range(0, QUEUES - 1);
            pick = $urandom_range(0, 99);
            case (mode)
                FILL_MODE:
                    req.op = (pick < 45) ? OP_PUSH_BACK : (pick < 88) ? OP_PUSH_FRONT :
                             (pick < 98) ? OP_POP_FRONT : OP_NONE;
                DRAIN_MODE:
                    req.op = (pick < 8) ? OP_PUSH_BACK : (pick < 15) ? OP_PUSH_FRONT :
                             (pick < 97) ? OP_POP_FRONT : OP_NONE;
                default:
                    req.op = (pick < 30) ? OP_PUSH_BACK : (pick < 60) ? OP_PUSH_FRONT :
                             (pick < 96) ? OP_POP_FRONT : OP_NONE;
            endcase
            req.player         = 2'(qi / GROUPS);
            req.group          = 3'(qi % GROUPS);
            req.rec.kind       = 16'($urandom);
            req.rec.pending    = $urandom;
            req.rec.arg_a      = $urandom;
            req.rec.arg_b      = $urandom;
            req.rec.arg_c      = $urandom;
            req.rec.arg_d      = $urandom;
            req.rec.sub_kind   = 16'($urandom);
            req.rec.queued_at  = $urandom;
            req.rec.started_at = $urandom;
            req.now            = $urandom;
            send_request(req, 1'b0, typed_res);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== multi_queue_task_deque.f =====
+incdir+rtl/core
rtl/core/mqtd_pkg.sv
rtl/core/mqtd_front.sv
rtl/core/mqtd_back.sv
rtl/core/multi_queue_task_deque.sv
rtl/core/mqtd_chk.sv
dv/tb.sv
